>>> rtl/ssem_pkg.sv
package ssem_pkg;

	// field widths fixed by the item format
	localparam int WORD_W = 32;
	localparam int ADDR_W = 5;
	localparam int OP_W   = 2;
	localparam int FUNC_W = 3;

	// instruction word layout
	localparam int FUNC_LSB = 13;
	localparam int LINE_LSB = 0;

	// item operation codes
	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_EXEC  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// instruction function codes
	typedef enum logic [FUNC_W-1:0] {
		FN_JMP  = 3'd0,
		FN_JRP  = 3'd1,
		FN_LDN  = 3'd2,
		FN_STO  = 3'd3,
		FN_SUB  = 3'd4,
		FN_SUBA = 3'd5,
		FN_CMP  = 3'd6,
		FN_STP  = 3'd7
	} func_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDWAIT,
		ST_FETCH,
		ST_OPER,
		ST_EMIT
	} state_t;

	// register updates produced by one executed instruction
	typedef struct packed {
		logic [WORD_W-1:0] acc;
		logic [WORD_W-1:0] ci;
		logic              stop;
		logic              store_we;
	} exec_upd_t;

endpackage

>>> rtl/ssem_req_if.sv
interface ssem_req_if;
	logic                            valid;
	logic                            ready;
	logic [ssem_pkg::OP_W-1:0]       operation;
	logic [ssem_pkg::ADDR_W-1:0]     line_address;
	logic [ssem_pkg::WORD_W-1:0]     write_data;

	modport source (output valid, output operation, output line_address,
		output write_data, input ready);
	modport sink (input valid, input operation, input line_address,
		input write_data, output ready);
endinterface

>>> rtl/ssem_rsp_if.sv
interface ssem_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [ssem_pkg::WORD_W-1:0]     read_data;
	logic [ssem_pkg::WORD_W-1:0]     accumulator_value;
	logic [ssem_pkg::WORD_W-1:0]     counter_value;
	logic                            stopped;
	logic [ssem_pkg::FUNC_W-1:0]     function_done;

	modport source (output valid, output read_data, output accumulator_value,
		output counter_value, output stopped, output function_done, input ready);
	modport sink (input valid, input read_data, input accumulator_value,
		input counter_value, input stopped, input function_done, output ready);
endinterface

>>> rtl/ssem_ram.sv
module ssem_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/ssem_exec.sv
module ssem_exec (
	input  ssem_pkg::func_t                func,
	input  logic [ssem_pkg::WORD_W-1:0]    acc,
	input  logic [ssem_pkg::WORD_W-1:0]    ci,
	input  logic [ssem_pkg::WORD_W-1:0]    operand,
	output ssem_pkg::exec_upd_t            upd
);

	// next accumulator, counter and stop flag for one instruction
	always_comb begin
		upd          = '0;
		upd.acc      = acc;
		upd.ci       = ci;
		upd.stop     = 1'b0;
		upd.store_we = 1'b0;
		case (func)
			ssem_pkg::FN_JMP:  upd.ci = operand;
			ssem_pkg::FN_JRP:  upd.ci = ci + operand;
			ssem_pkg::FN_LDN:  upd.acc = '0 - operand;
			ssem_pkg::FN_STO:  upd.store_we = 1'b1;
			ssem_pkg::FN_SUB,
			ssem_pkg::FN_SUBA: upd.acc = acc - operand;
			ssem_pkg::FN_CMP: begin
				if (acc[ssem_pkg::WORD_W-1]) begin
					upd.ci = ci + ssem_pkg::WORD_W'(1);
				end
			end
			ssem_pkg::FN_STP:  upd.stop = 1'b1;
			default:           upd.stop = 1'b0;
		endcase
	end

endmodule

>>> rtl/ssem_processor_step.sv
// Manchester Baby processor step. Each transaction on req writes a store line,
// reads a store line or executes one instruction (none once stopped), and gives exactly one
// transaction on rsp carrying the read word, the accumulator, the control
// counter, the stop flag and the executed function code. The store sits in a
// single synchronous RAM with one read and one write port, so an instruction
// passes through counter update and fetch read, operand read, execute and the
// result register; a read through the store read, the read register and the
// result register, a write or an idle operation through the result register. The
// store reads as zero after reset: a valid bit per line masks unwritten lines.
module ssem_processor_step #(
	parameter int STORE_LINES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	ssem_req_if.sink    req,
	ssem_rsp_if.source  rsp
);

	localparam int AW = $clog2(STORE_LINES);
	localparam int WW = ssem_pkg::WORD_W;

	ssem_pkg::state_t     state_q, state_d;
	logic [WW-1:0]        acc_q;
	logic [WW-1:0]        ci_q;
	logic                 stop_q;
	logic [STORE_LINES-1:0] valid_q;

	logic [WW-1:0]        rd_q;
	ssem_pkg::func_t      func_q;
	logic [AW-1:0]        s_q;
	logic [AW-1:0]        raddr_q;

	logic                 out_valid_q;
	logic [WW-1:0]        out_rd_q;
	logic [WW-1:0]        out_acc_q;
	logic [WW-1:0]        out_ci_q;
	logic                 out_stop_q;
	ssem_pkg::func_t      out_func_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WW-1:0]        ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WW-1:0]        ram_rdata;
	logic [WW-1:0]        rd_word;

	logic                 accept;
	logic                 exec_go;
	logic                 emit_go;
	logic [WW-1:0]        ci_inc;
	ssem_pkg::op_t        op;
	ssem_pkg::exec_upd_t  upd;

	ssem_ram #(
		.WIDTH (WW),
		.DEPTH (STORE_LINES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ssem_exec u_exec (
		.func    (func_q),
		.acc     (acc_q),
		.ci      (ci_q),
		.operand (rd_word),
		.upd     (upd)
	);

	// handshake and decode
	assign op      = ssem_pkg::op_t'(req.operation);
	assign accept  = req.valid && req.ready;
	assign exec_go = accept && (op == ssem_pkg::OP_EXEC) && !stop_q;
	assign emit_go = (state_q == ssem_pkg::ST_EMIT) && (!out_valid_q || rsp.ready);
	assign ci_inc  = ci_q + WW'(1);

	// unwritten lines read as zero
	assign rd_word = valid_q[raddr_q] ? ram_rdata : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ssem_pkg::ST_IDLE: begin
				if (accept) begin
					if (op == ssem_pkg::OP_READ) begin
						state_d = ssem_pkg::ST_RDWAIT;
					end else if (exec_go) begin
						state_d = ssem_pkg::ST_FETCH;
					end else begin
						state_d = ssem_pkg::ST_EMIT;
					end
				end
			end
			ssem_pkg::ST_RDWAIT: state_d = ssem_pkg::ST_EMIT;
			ssem_pkg::ST_FETCH:  state_d = ssem_pkg::ST_OPER;
			ssem_pkg::ST_OPER:   state_d = ssem_pkg::ST_EMIT;
			ssem_pkg::ST_EMIT: begin
				if (emit_go) begin
					state_d = ssem_pkg::ST_IDLE;
				end
			end
			default: state_d = ssem_pkg::ST_IDLE;
		endcase
	end

	// memory port control and ready
	always_comb begin
		req.ready = (state_q == ssem_pkg::ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = req.line_address[AW-1:0];
		ram_wdata = req.write_data;
		ram_raddr = ci_inc[AW-1:0];
		case (state_q)
			ssem_pkg::ST_IDLE: begin
				ram_we = accept && (op == ssem_pkg::OP_WRITE);
				if (op == ssem_pkg::OP_READ) begin
					ram_raddr = req.line_address[AW-1:0];
				end
			end
			ssem_pkg::ST_FETCH: begin
				ram_raddr = rd_word[ssem_pkg::LINE_LSB +: AW];
			end
			ssem_pkg::ST_OPER: begin
				ram_we    = upd.store_we;
				ram_waddr = s_q;
				ram_wdata = acc_q;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// architectural state and line valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssem_pkg::ST_IDLE;
			acc_q   <= '0;
			ci_q    <= '0;
			stop_q  <= 1'b0;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (exec_go) begin
				ci_q <= ci_inc;
			end
			if (state_q == ssem_pkg::ST_OPER) begin
				acc_q <= upd.acc;
				ci_q  <= upd.ci;
				if (upd.stop) begin
					stop_q <= 1'b1;
				end
			end
		end
	end

	// per-transaction working registers
	always_ff @(posedge clk) begin
		raddr_q <= ram_raddr;
		if (accept) begin
			rd_q   <= '0;
			func_q <= ssem_pkg::FN_JMP;
		end
		if (state_q == ssem_pkg::ST_RDWAIT) begin
			rd_q <= rd_word;
		end
		if (state_q == ssem_pkg::ST_FETCH) begin
			s_q    <= rd_word[ssem_pkg::LINE_LSB +: AW];
			func_q <= ssem_pkg::func_t'(rd_word[ssem_pkg::FUNC_LSB +: ssem_pkg::FUNC_W]);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_rd_q   <= rd_q;
			out_acc_q  <= acc_q;
			out_ci_q   <= ci_q;
			out_stop_q <= stop_q;
			out_func_q <= func_q;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.read_data         = out_rd_q;
	assign rsp.accumulator_value = out_acc_q;
	assign rsp.counter_value     = out_ci_q;
	assign rsp.stopped           = out_stop_q;
	assign rsp.function_done     = out_func_q;

	// once stopped the machine stays stopped
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |=> stop_q)
		else $error("stop flag cleared");

	// an instruction on a running machine always starts with its fetch
	a_exec_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> (state_q == ssem_pkg::ST_FETCH))
		else $error("instruction did not enter fetch");

	// store writes only from a write transaction or a store instruction
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ssem_pkg::ST_IDLE || state_q == ssem_pkg::ST_OPER))
		else $error("store written outside write or execute");

	// a pending result is never overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |-> !emit_go)
		else $error("result register overwritten");

endmodule

>>> tb/sv/ssem_step_checker.sv
`timescale 1ns / 1ps

module ssem_step_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	ssem_req_if                           req,
	ssem_rsp_if                           rsp,
	output int                            mismatches,
	output int                            outstanding,
	output int                            compared,
	output logic [ssem_pkg::ADDR_W-1:0]   next_line,
	output logic                          next_halts,
	output logic [7:0]                    funcs_seen
);

	localparam int AW    = ssem_pkg::ADDR_W;
	localparam int WW    = ssem_pkg::WORD_W;
	localparam int FW    = ssem_pkg::FUNC_W;
	localparam int LINES = 1 << AW;

	typedef struct packed {
		logic [WW-1:0] rd;
		logic [WW-1:0] acc;
		logic [WW-1:0] ci;
		logic          stop;
		logic [FW-1:0] fn;
	} step_result_t;

	// machine image kept in step with the block
	logic [WW-1:0]     store_img [LINES];
	logic [WW-1:0]     acc_q;
	logic [WW-1:0]     ci_q;
	logic              halt_q;
	step_result_t      pending_results [$];

	// line the next instruction step will fetch, and whether it holds a stop
	assign next_line  = ci_q[AW-1:0] + AW'(1);
	assign next_halts = !halt_q
		&& (store_img[next_line][ssem_pkg::FUNC_LSB +: FW] == ssem_pkg::FN_STP);

	// apply one transaction to the image and give the result it should produce
	task automatic step_machine(input ssem_pkg::op_t op, input logic [AW-1:0] addr,
		input logic [WW-1:0] data, output step_result_t res);
		logic [WW-1:0]     word;
		logic [WW-1:0]     operand;
		logic [AW-1:0]     s;
		ssem_pkg::func_t   fn;
		res = '0;
		case (op)
			ssem_pkg::OP_WRITE: begin
				store_img[addr] = data;
			end
			ssem_pkg::OP_READ: begin
				res.rd = store_img[addr];
			end
			ssem_pkg::OP_EXEC: begin
				if (!halt_q) begin
					ci_q = ci_q + WW'(1);
					word = store_img[ci_q[AW-1:0]];
					s = word[ssem_pkg::LINE_LSB +: AW];
					fn = ssem_pkg::func_t'(word[ssem_pkg::FUNC_LSB +: FW]);
					operand = store_img[s];
					case (fn)
						ssem_pkg::FN_JMP: ci_q = operand;
						ssem_pkg::FN_JRP: ci_q = ci_q + operand;
						ssem_pkg::FN_LDN: acc_q = '0 - operand;
						ssem_pkg::FN_STO: store_img[s] = acc_q;
						ssem_pkg::FN_SUB, ssem_pkg::FN_SUBA: acc_q = acc_q - operand;
						ssem_pkg::FN_CMP: if (acc_q[WW-1]) ci_q = ci_q + WW'(1);
						default: halt_q = 1'b1;
					endcase
					res.fn = fn;
					funcs_seen[fn] = 1'b1;
				end
			end
			default: ;
		endcase
		res.acc  = acc_q;
		res.ci   = ci_q;
		res.stop = halt_q;
	endtask

	task automatic check_field(input string name, input logic [WW-1:0] want,
		input logic [WW-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// predict on each accepted request, compare on each accepted response
	always @(posedge clk or negedge arst_n) begin
		step_result_t want;
		step_result_t got;
		if (!arst_n) begin
			foreach (store_img[i]) store_img[i] = '0;
			acc_q       = '0;
			ci_q        = '0;
			halt_q      = 1'b0;
			funcs_seen  = '0;
			outstanding = 0;
			mismatches  = 0;
			compared    = 0;
			pending_results.delete();
		end else begin
			if (req.valid && req.ready) begin
				step_machine(ssem_pkg::op_t'(req.operation), req.line_address,
					req.write_data, want);
				pending_results.push_back(want);
			end
			if (rsp.valid && rsp.ready) begin
				got.rd   = rsp.read_data;
				got.acc  = rsp.accumulator_value;
				got.ci   = rsp.counter_value;
				got.stop = rsp.stopped;
				got.fn   = rsp.function_done;
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: response with nothing expected, expected none, actual %h",
						$time, got);
				end else begin
					want = pending_results.pop_front();
					check_field("read_data", want.rd, got.rd);
					check_field("accumulator_value", want.acc, got.acc);
					check_field("counter_value", want.ci, got.ci);
					check_field("stopped", WW'(want.stop), WW'(got.stop));
					check_field("function_done", WW'(want.fn), WW'(got.fn));
					compared++;
				end
			end
			outstanding = pending_results.size();
		end
	end

endmodule

>>> tb/sv/ssem_processor_step_tb.sv
`timescale 1ns / 1ps

module ssem_processor_step_tb;

	localparam int AW = ssem_pkg::ADDR_W;
	localparam int WW = ssem_pkg::WORD_W;
	localparam int FW = ssem_pkg::FUNC_W;

	localparam int RANDOM_ITEMS = 1700;
	localparam int HOLD_CYCLES  = 200;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk;
	logic arst_n;
	logic hold_req;

	ssem_req_if req ();
	ssem_rsp_if rsp ();

	int               mismatches;
	int               outstanding;
	int               compared;
	logic [AW-1:0]    next_line;
	logic             next_halts;
	logic [7:0]       funcs_seen;

	int sent_total;
	int op_count [4];
	int burst_left;

	ssem_processor_step i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	ssem_step_checker i_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared),
		.next_line   (next_line),
		.next_halts  (next_halts),
		.funcs_seen  (funcs_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("run did not finish within %0d cycles", CYCLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// response side: random stall pattern, plus one long hold-off on request
	initial begin : receiver
		int  mode;
		int  stretch;
		bit  hold_served;
		hold_served = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			stretch = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(8, 60);
			repeat (stretch) begin
				if (hold_req && !hold_served) begin
					rsp.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_served = 1'b1;
				end else begin
					case (mode)
						0: rsp.ready <= 1'b1;
						1: rsp.ready <= 1'($urandom_range(0, 1));
						2: rsp.ready <= ($urandom_range(0, 3) == 0);
						default: rsp.ready <= 1'b0;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	function automatic logic [WW-1:0] instr(input ssem_pkg::func_t fn,
		input logic [AW-1:0] s);
		logic [WW-1:0] w;
		w = '0;
		w[ssem_pkg::FUNC_LSB +: FW] = fn;
		w[ssem_pkg::LINE_LSB +: AW] = s;
		return w;
	endfunction

	// mix of runnable instructions, small jump values and raw words
	function automatic logic [WW-1:0] random_word();
		logic [WW-1:0] w;
		w = $urandom;
		case ($urandom_range(0, 3))
			0, 1: w[ssem_pkg::FUNC_LSB +: FW] = FW'($urandom_range(
				int'(ssem_pkg::FN_JMP), int'(ssem_pkg::FN_CMP)));
			2: w = $urandom_range(0, 40);
			default: ;
		endcase
		return w;
	endfunction

	// one transaction, held until accepted; entered and left on a rising edge
	task automatic offer(input ssem_pkg::op_t op, input logic [AW-1:0] addr,
		input logic [WW-1:0] data);
		req.operation    <= op;
		req.line_address <= addr;
		req.write_data   <= data;
		req.valid        <= 1'b1;
		do @(posedge clk); while (!req.ready);
		sent_total++;
		op_count[op]++;
	endtask

	task automatic pause(input int cycles);
		req.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// sender bursts with random gaps between them
	task automatic burst_gap();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) pause(gap);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task automatic send(input ssem_pkg::op_t op, input logic [AW-1:0] addr,
		input logic [WW-1:0] data);
		burst_gap();
		offer(op, addr, data);
	endtask

	// instruction step; unless a stop is wanted, a stop word about to be
	// fetched is first overwritten so the machine keeps running
	task automatic step_exec(input bit let_halt);
		bit                clear;
		logic [AW-1:0]     line;
		logic [WW-1:0]     w;
		burst_gap();
		clear = 1'b0;
		while (!clear) begin
			req.valid <= 1'b0;
			@(negedge clk);
			clear = let_halt || !next_halts;
			line = next_line;
			@(posedge clk);
			if (!clear) begin
				w = $urandom;
				w[ssem_pkg::FUNC_LSB +: FW] = FW'($urandom_range(
					int'(ssem_pkg::FN_JMP), int'(ssem_pkg::FN_CMP)));
				offer(ssem_pkg::OP_WRITE, line, w);
			end
		end
		offer(ssem_pkg::OP_EXEC, AW'($urandom), $urandom);
	endtask

	// wait until every expected result is in
	task automatic drain();
		req.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_program();
		repeat ($urandom_range(2, 12))
			send(ssem_pkg::OP_WRITE, AW'($urandom), random_word());
		repeat ($urandom_range(3, 16)) begin
			if ($urandom_range(0, 7) == 0)
				send(($urandom_range(0, 2) == 0) ? ssem_pkg::OP_READ : ssem_pkg::OP_NONE,
					AW'($urandom), $urandom);
			else
				step_exec(1'b0);
		end
	endtask

	task automatic random_noise();
		ssem_pkg::op_t op;
		repeat ($urandom_range(3, 12)) begin
			op = ssem_pkg::op_t'($urandom_range(int'(ssem_pkg::OP_WRITE),
				int'(ssem_pkg::OP_NONE)));
			if (op == ssem_pkg::OP_EXEC)
				step_exec(1'b0);
			else
				send(op, AW'($urandom), $urandom);
		end
	endtask

	// stimulus
	initial begin : sender
		int  target;
		bit  pressed;
		bit  drained;
		req.valid        <= 1'b0;
		req.operation    <= ssem_pkg::OP_NONE;
		req.line_address <= '0;
		req.write_data   <= '0;
		hold_req         <= 1'b0;
		arst_n           <= 1'b0;
		sent_total = 0;
		burst_left = 0;
		foreach (op_count[i]) op_count[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unwritten line reads zero, field extremes, unused operation
		send(ssem_pkg::OP_READ, 5'd0, '0);
		send(ssem_pkg::OP_WRITE, 5'd31, '1);
		send(ssem_pkg::OP_WRITE, 5'd0, '0);
		send(ssem_pkg::OP_READ, 5'd31, '0);
		send(ssem_pkg::OP_NONE, 5'd31, '1);
		// operands and a small program covering every function but stop
		send(ssem_pkg::OP_WRITE, 5'd30, 32'd5);
		send(ssem_pkg::OP_WRITE, 5'd28, 32'd3);
		send(ssem_pkg::OP_WRITE, 5'd27, 32'hFFFF_FFFF);
		send(ssem_pkg::OP_WRITE, 5'd1, instr(ssem_pkg::FN_LDN, 5'd31));
		send(ssem_pkg::OP_WRITE, 5'd2, instr(ssem_pkg::FN_SUB, 5'd30));
		send(ssem_pkg::OP_WRITE, 5'd3, instr(ssem_pkg::FN_CMP, 5'd0));
		send(ssem_pkg::OP_WRITE, 5'd4, instr(ssem_pkg::FN_SUBA, 5'd30));
		send(ssem_pkg::OP_WRITE, 5'd5, instr(ssem_pkg::FN_STO, 5'd29));
		send(ssem_pkg::OP_WRITE, 5'd6, instr(ssem_pkg::FN_SUBA, 5'd29));
		send(ssem_pkg::OP_WRITE, 5'd7, instr(ssem_pkg::FN_CMP, 5'd0));
		send(ssem_pkg::OP_WRITE, 5'd8, instr(ssem_pkg::FN_JRP, 5'd28));
		send(ssem_pkg::OP_WRITE, 5'd12, instr(ssem_pkg::FN_JMP, 5'd27));
		// negate, subtract to negative, skip taken, store, zero, skip not
		// taken, relative jump, jump to all ones so the counter wraps to zero,
		// then a zero word runs as a jump
		repeat (9) step_exec(1'b0);
		send(ssem_pkg::OP_READ, 5'd29, '0);

		// random part: mostly programs, some noise
		target = sent_total + RANDOM_ITEMS;
		pressed = 1'b0;
		drained = 1'b0;
		while (sent_total < target) begin
			if ($urandom_range(0, 9) < 7)
				random_program();
			else
				random_noise();
			if (!drained && sent_total > target - (2 * RANDOM_ITEMS) / 3) begin
				drain();
				drained = 1'b1;
			end
			if (!pressed && sent_total > target - RANDOM_ITEMS / 3) begin
				// long response hold-off while requests keep coming back to back
				hold_req <= 1'b1;
				repeat (30) offer(ssem_pkg::op_t'($urandom_range(int'(ssem_pkg::OP_WRITE),
					int'(ssem_pkg::OP_READ))), AW'($urandom), $urandom);
				pressed = 1'b1;
			end
		end

		// stopped machine: plant a stop, run it, then steps do nothing
		step_exec(1'b0);
		req.valid <= 1'b0;
		@(negedge clk);
		@(posedge clk);
		offer(ssem_pkg::OP_WRITE, next_line, instr(ssem_pkg::FN_STP, AW'($urandom)));
		repeat (4) step_exec(1'b1);
		send(ssem_pkg::OP_WRITE, AW'($urandom), $urandom);
		send(ssem_pkg::OP_READ, AW'($urandom), '0);

		drain();
		$display("%0d transactions: %0d writes, %0d reads, %0d steps, %0d unused",
			sent_total, op_count[ssem_pkg::OP_WRITE], op_count[ssem_pkg::OP_READ],
			op_count[ssem_pkg::OP_EXEC], op_count[ssem_pkg::OP_NONE]);
		$display("%0d responses compared, function codes executed %b", compared, funcs_seen);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
